>>> rtl/aapc_pkg.sv
// Shared types for the all-pairs box collision block.
// Beat payloads, stored box record and per-cell control. No dependencies.
package aapc_pkg;

   localparam int unsigned MaskOutWidth = 16;

   typedef struct packed {
      logic        [15:0] entity_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] off_x;
      logic signed [15:0] off_y;
      logic        [14:0] box_width;
      logic        [14:0] box_height;
      logic               last_box;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]             out_entity_id;
      logic                    killed;
      logic [MaskOutWidth-1:0] partner_mask;
      logic                    overflow;
      logic                    last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic        [15:0] entity_id;
      logic signed [16:0] x_lo;
      logic signed [17:0] x_hi;
      logic signed [16:0] y_lo;
      logic signed [17:0] y_hi;
   } box_type;

   typedef struct packed {
      logic cmp_en;
      logic store;
      logic shift;
   } cell_ctrl_type;

endpackage

>>> rtl/aapc_if.sv
// Valid/ready channel interfaces for box beats and result beats.
// Depends on aapc_pkg for the payload types.
interface aapc_req_if;
   import aapc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface aapc_rsp_if;
   import aapc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/aapc_edge.sv
// Edge stage: turns an accepted box beat into registered low/high edges.
// Depends on aapc_pkg.
module aapc_edge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  aapc_pkg::req_payload_type req_beat,
   output logic                      stg_valid,
   output aapc_pkg::box_type         stg_box,
   output logic                      stg_last
);
   import aapc_pkg::*;

   logic    valid_ff;
   box_type box_ff;
   box_type box_in;
   logic    last_ff;

   always_comb begin
      box_in.entity_id = req_beat.entity_id;
      box_in.x_lo = $signed({req_beat.pos_x[15], req_beat.pos_x})
                  + $signed({req_beat.off_x[15], req_beat.off_x});
      box_in.y_lo = $signed({req_beat.pos_y[15], req_beat.pos_y})
                  + $signed({req_beat.off_y[15], req_beat.off_y});
      box_in.x_hi = $signed({box_in.x_lo[16], box_in.x_lo})
                  + $signed({3'b000, req_beat.box_width});
      box_in.y_hi = $signed({box_in.y_lo[16], box_in.y_lo})
                  + $signed({3'b000, req_beat.box_height});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         box_ff  <= box_in;
         last_ff <= req_beat.last_box;
      end
   end

   assign stg_valid = valid_ff;
   assign stg_box   = box_ff;
   assign stg_last  = last_ff;

endmodule

>>> rtl/aapc_cell.sv
// One storage cell of the box chain: holds a box and its partner mask,
// tests the broadcast box, shifts towards the output when draining. Depends on aapc_pkg.
module aapc_cell #(
   parameter int unsigned NBOX = 16
) (
   input  logic                    clock,
   input  aapc_pkg::cell_ctrl_type ctrl,
   input  aapc_pkg::box_type       new_box,
   input  logic [NBOX-1:0]         new_hits,
   input  logic [NBOX-1:0]         slot_bit,
   input  aapc_pkg::box_type       nbr_box,
   input  logic [NBOX-1:0]         nbr_mask,
   output logic                    hit,
   output aapc_pkg::box_type       cur_box,
   output logic [NBOX-1:0]         cur_mask
);
   import aapc_pkg::*;

   box_type         box_ff;
   logic [NBOX-1:0] mask_ff;
   logic            x_cross;
   logic            y_cross;

   assign x_cross = ($signed({box_ff.x_lo[16], box_ff.x_lo}) < new_box.x_hi)
                 && (box_ff.x_hi > $signed({new_box.x_lo[16], new_box.x_lo}));
   assign y_cross = ($signed({box_ff.y_lo[16], box_ff.y_lo}) < new_box.y_hi)
                 && (box_ff.y_hi > $signed({new_box.y_lo[16], new_box.y_lo}));
   assign hit = ctrl.cmp_en && x_cross && y_cross;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         box_ff  <= nbr_box;
         mask_ff <= nbr_mask;
      end else if (ctrl.store) begin
         box_ff  <= new_box;
         mask_ff <= new_hits;
      end else if (hit) begin
         mask_ff <= mask_ff | slot_bit;
      end
   end

   assign cur_box  = box_ff;
   assign cur_mask = mask_ff;

endmodule

>>> rtl/aabb_all_pairs_collision_top.sv
// All-pairs box collision top: edge stage, then a chain of MAX_BOXES cells.
// Throughput one box beat per cycle in fill; a box is tested and stored (dropped if full)
// in the cycle after its beat. Once the final beat passes the edge stage, the chain drains
// one result per cycle while ready towards cell 0; beats after the final one wait till empty.
// Synchronous reset clears state and count; the cells need no clearing pass.
module aabb_all_pairs_collision_top #(
   parameter int unsigned MAX_BOXES = 16
) (
   input  logic        clock,
   input  logic        reset,
   aapc_req_if.sink    req_chan,
   aapc_rsp_if.source  rsp_chan
);
   import aapc_pkg::*;

   localparam int unsigned CW = $clog2(MAX_BOXES + 1);
   localparam int unsigned MaskPad = (MAX_BOXES > MaskOutWidth) ? MAX_BOXES : MaskOutWidth;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } fsm_state_type;

   fsm_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;

   logic          take;
   logic          rsp_take;
   logic          stg_valid;
   box_type       stg_box;
   logic          stg_last;
   logic          full;
   logic          process;

   logic [MAX_BOXES-1:0] hit_vec;
   logic [MAX_BOXES-1:0] slot_bit;
   box_type              cell_box [MAX_BOXES];
   logic [MAX_BOXES-1:0] cell_mask [MAX_BOXES];
   logic [MaskPad-1:0]   mask_pad;

   assign req_chan.ready = (state_ff == ST_FILL) && !(stg_valid && stg_last);
   assign take     = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign full     = (count_ff == CW'(MAX_BOXES));
   assign process  = stg_valid && (state_ff == ST_FILL) && !full;
   assign slot_bit = {{(MAX_BOXES-1){1'b0}}, 1'b1} << count_ff;

   aapc_edge u_edge (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_beat  (req_chan.payload),
      .stg_valid (stg_valid),
      .stg_box   (stg_box),
      .stg_last  (stg_last)
   );

   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      cell_ctrl_type   ctrl;
      box_type         nbr_box;
      logic [MAX_BOXES-1:0] nbr_mask;

      assign ctrl.cmp_en = process && (CW'(i) < count_ff);
      assign ctrl.store  = process && (CW'(i) == count_ff);
      assign ctrl.shift  = (state_ff == ST_DRAIN) && rsp_take;

      if (i == MAX_BOXES - 1) begin : g_end
         assign nbr_box  = '0;
         assign nbr_mask = '0;
      end else begin : g_mid
         assign nbr_box  = cell_box[i+1];
         assign nbr_mask = cell_mask[i+1];
      end

      aapc_cell #(.NBOX(MAX_BOXES)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .new_box  (stg_box),
         .new_hits (hit_vec),
         .slot_bit (slot_bit),
         .nbr_box  (nbr_box),
         .nbr_mask (nbr_mask),
         .hit      (hit_vec[i]),
         .cur_box  (cell_box[i]),
         .cur_mask (cell_mask[i])
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_FILL: begin
            if (stg_valid) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (stg_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take) begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in   = ST_FILL;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign mask_pad = MaskPad'(cell_mask[0]);

   assign rsp_chan.valid                 = (state_ff == ST_DRAIN);
   assign rsp_chan.payload.out_entity_id = cell_box[0].entity_id;
   assign rsp_chan.payload.killed        = |cell_mask[0];
   assign rsp_chan.payload.partner_mask  = mask_pad[MaskOutWidth-1:0];
   assign rsp_chan.payload.overflow      = dropped_ff;
   assign rsp_chan.payload.last_result   = (count_ff == CW'(1));

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> count_ff != '0)
      else $error("result offered with no stored box");

   a_no_take_in_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> !req_chan.ready)
      else $error("box beat taken while draining");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_chan.payload.last_result |=> state_ff == ST_FILL && count_ff == '0
      && !dropped_ff)
      else $error("frame not cleared after final result");

   a_hit_below_count: assert property (@(posedge clock) disable iff (reset)
      (hit_vec & ~(slot_bit - MAX_BOXES'(1))) == '0)
      else $error("hit from a cell beyond the stored boxes");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for aabb_all_pairs_collision_top: streams frames of boxes, predicts the per-box
// reports in the bench and checks each result beat field by field. Needs aapc_pkg, aapc_if.
module tb_top;
   import aapc_pkg::*;

   localparam int unsigned MAX_BOXES   = 16;
   localparam int          HOLD_CYCLES = 300;
   localparam int          STALL_LIMIT = 4000;
   localparam int          TAIL_CYCLES = 20;
   localparam int          RANDOM_BOXES = 200;

   logic clock;
   logic reset;

   aapc_req_if req_bus ();
   aapc_rsp_if rsp_bus ();

   aabb_all_pairs_collision_top #(
      .MAX_BOXES(MAX_BOXES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   int                    lo_x [MAX_BOXES];
   int                    hi_x [MAX_BOXES];
   int                    lo_y [MAX_BOXES];
   int                    hi_y [MAX_BOXES];
   logic [15:0]           held_ids [MAX_BOXES];
   logic [MAX_BOXES-1:0]  hit_masks [MAX_BOXES];
   int                    held_count;
   bit                    boxes_dropped;

   rsp_payload_type pending_reports [$];
   int              fail_count;
   int              hold_asks;
   bit              no_idle;
   int              boxes_sent;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_frame();
      for (int k = 0; k < MAX_BOXES; k++) hit_masks[k] = '0;
      held_count    = 0;
      boxes_dropped = 1'b0;
   endfunction

   function automatic void predict_box(req_payload_type b);
      int xl, yl, xh, yh, n;
      rsp_payload_type r;
      if (held_count < MAX_BOXES) begin
         n  = held_count;
         xl = $signed(b.pos_x) + $signed(b.off_x);
         yl = $signed(b.pos_y) + $signed(b.off_y);
         xh = xl + int'(b.box_width);
         yh = yl + int'(b.box_height);
         for (int i = 0; i < n; i++) begin
            if (lo_x[i] < xh && hi_x[i] > xl && lo_y[i] < yh && hi_y[i] > yl) begin
               hit_masks[i][n] = 1'b1;
               hit_masks[n][i] = 1'b1;
            end
         end
         lo_x[n]     = xl;
         hi_x[n]     = xh;
         lo_y[n]     = yl;
         hi_y[n]     = yh;
         held_ids[n] = b.entity_id;
         held_count  = n + 1;
      end else begin
         boxes_dropped = 1'b1;
      end
      if (b.last_box) begin
         for (int k = 0; k < held_count; k++) begin
            r.out_entity_id = held_ids[k];
            r.killed        = |hit_masks[k];
            r.partner_mask  = hit_masks[k][MaskOutWidth-1:0];
            r.overflow      = boxes_dropped;
            r.last_result   = (k + 1 == held_count);
            pending_reports.push_back(r);
         end
         clear_frame();
      end
   endfunction

   task automatic check_report(rsp_payload_type got);
      rsp_payload_type want;
      if (pending_reports.size() == 0) begin
         $error("unexpected result beat: id %h", got.out_entity_id);
         fail_count++;
      end else begin
         want = pending_reports.pop_front();
         if (got.out_entity_id !== want.out_entity_id) begin
            $error("out_entity_id: expected %h, got %h", want.out_entity_id, got.out_entity_id);
            fail_count++;
         end
         if (got.killed !== want.killed) begin
            $error("killed: expected %b, got %b", want.killed, got.killed);
            fail_count++;
         end
         if (got.partner_mask !== want.partner_mask) begin
            $error("partner_mask: expected %h, got %h", want.partner_mask, got.partner_mask);
            fail_count++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, got.overflow);
            fail_count++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result: expected %b, got %b", want.last_result, got.last_result);
            fail_count++;
         end
      end
   endtask

   // result side: check accepted beats, then pick ready for the next edge
   initial begin
      int left;
      int served;
      left   = 0;
      served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) check_report(rsp_bus.payload);
         if (hold_asks != served) begin
            served = hold_asks;
            left   = HOLD_CYCLES;
         end
         if (left > 0) begin
            left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= 33);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
         else quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic req_payload_type make_box(logic [15:0] id, logic [15:0] px,
                                                logic [15:0] py, logic [15:0] ox,
                                                logic [15:0] oy, logic [14:0] w,
                                                logic [14:0] h, bit last);
      req_payload_type b;
      b.entity_id  = id;
      b.pos_x      = px;
      b.pos_y      = py;
      b.off_x      = ox;
      b.off_y      = oy;
      b.box_width  = w;
      b.box_height = h;
      b.last_box   = last;
      return b;
   endfunction

   function automatic req_payload_type random_box(bit last);
      req_payload_type b;
      b.entity_id = 16'($urandom);
      b.last_box  = last;
      if ($urandom_range(3) == 0) begin
         b.pos_x      = 16'($urandom);
         b.pos_y      = 16'($urandom);
         b.off_x      = 16'($urandom);
         b.off_y      = 16'($urandom);
         b.box_width  = 15'($urandom);
         b.box_height = 15'($urandom);
      end else begin
         b.pos_x      = 16'($urandom_range(128) - 64);
         b.pos_y      = 16'($urandom_range(128) - 64);
         b.off_x      = 16'($urandom_range(32) - 16);
         b.off_y      = 16'($urandom_range(32) - 16);
         b.box_width  = 15'($urandom_range(40));
         b.box_height = 15'($urandom_range(40));
      end
      return b;
   endfunction

   task automatic send_box(req_payload_type b);
      while (!no_idle && $urandom_range(99) < 33) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= b;
      do @(posedge clock); while (!req_bus.ready);
      predict_box(b);
      boxes_sent++;
   endtask

   task automatic end_burst();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_reports_done();
      end_burst();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_frame(int n);
      for (int i = 0; i < n; i++) send_box(random_box(i == n - 1));
   endtask

   task automatic test_touching_edges();
      send_box(make_box(16'h0001, 16'd0, 16'd0, 16'd0, 16'd0, 15'd10, 15'd10, 1'b0));
      send_box(make_box(16'h0002, 16'd10, 16'd0, 16'd0, 16'd0, 15'd10, 15'd10, 1'b0));
      send_box(make_box(16'h0003, 16'd0, 16'd10, 16'd0, 16'd0, 15'd10, 15'd10, 1'b0));
      send_box(make_box(16'h0004, 16'd9, 16'd9, 16'd0, 16'd0, 15'd1, 15'd1, 1'b1));
   endtask

   task automatic test_coordinate_extremes();
      send_box(make_box(16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'd0, 15'd0,
                        1'b0));
      send_box(make_box(16'h0005, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        15'h7fff, 15'h7fff, 1'b0));
      send_box(make_box(16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                        15'h7fff, 15'h7fff, 1'b1));
   endtask

   task automatic test_zero_size_and_shared_id();
      send_box(make_box(16'h1234, 16'd0, 16'd0, 16'd0, 16'd0, 15'd20, 15'd20, 1'b0));
      send_box(make_box(16'h1234, 16'd5, 16'd5, 16'd0, 16'd0, 15'd0, 15'd0, 1'b0));
      send_box(make_box(16'h4321, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0, 1'b1));
   endtask

   task automatic test_capacity_overflow();
      for (int i = 0; i <= MAX_BOXES; i++)
         send_box(make_box(16'(16'ha000 + i), 16'(i), 16'(i), 16'd0, 16'd0, 15'd100, 15'd100,
                           i == MAX_BOXES));
   endtask

   task automatic test_result_backpressure();
      wait_reports_done();
      hold_asks++;
      for (int f = 0; f < 3; f++) send_random_frame(6);
      wait_reports_done();
   endtask

   task automatic test_sender_pause();
      send_random_frame(5);
      wait_reports_done();
      send_random_frame(4);
      wait_reports_done();
   endtask

   task automatic test_random_frames();
      int start;
      int n;
      start = boxes_sent;
      while (boxes_sent - start < RANDOM_BOXES) begin
         no_idle = (boxes_sent - start < RANDOM_BOXES / 4);
         if ($urandom_range(7) == 0) n = int'($urandom_range(MAX_BOXES + 4, MAX_BOXES + 1));
         else n = int'($urandom_range(12, 1));
         send_random_frame(n);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      fail_count = 0;
      hold_asks  = 0;
      no_idle    = 1'b0;
      boxes_sent = 0;
      clear_frame();
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      reset           <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_touching_edges();
      test_coordinate_extremes();
      test_zero_size_and_shared_id();
      test_capacity_overflow();
      test_result_backpressure();
      test_sender_pause();
      test_random_frames();

      wait_reports_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d reports never arrived", pending_reports.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
